### design/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the segment crossing RTL.
// Included by the modules that check their own pipeline and queue logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define SGI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SGI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGI_ASSERT(lbl, clk, rst, prop, msg)
`define SGI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### design/sgi_pkg.sv
// sgi_pkg: shared constants and types of the segment crossing pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package sgi_pkg;

  // Default coordinate width, taken from the low bits of each field
  localparam int COORD_WIDTH = 32;
  // Width of every coordinate field on the ports
  localparam int FIELD_W = 32;
  localparam int IN_FIELDS = 8;
  localparam int IN_DATA_W = IN_FIELDS * FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;
  localparam int OUT_USER_W = 2;

  // Parallel threshold register
  localparam int THR_W = 63;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  // Control group that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic parallel;
    logic crosses;
  } ctl_t;

  // One finished result
  typedef struct packed {
    logic               parallel;
    logic               crosses;
    logic [FIELD_W-1:0] cross_y;
    logic [FIELD_W-1:0] cross_x;
  } res_t;

endpackage
`default_nettype wire

### design/sgi_front.sv
// sgi_front: coordinate differences, 2x2 products, determinant and numerators.
// Three register stages; uses sgi_pkg.
`default_nettype none
module sgi_front #(
  parameter int CW = sgi_pkg::COORD_WIDTH,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [sgi_pkg::IN_DATA_W-1:0] in_data,
  output logic                               out_valid,
  output logic signed [PW-1:0]               det,
  output logic signed [PW-1:0]               na,
  output logic signed [PW-1:0]               nb,
  output logic signed [DW-1:0]               a00,
  output logic signed [DW-1:0]               a10,
  output logic signed [DW-1:0]               a01,
  output logic signed [DW-1:0]               a11,
  output logic signed [DW-1:0]               sx,
  output logic signed [DW-1:0]               sy
);
  import sgi_pkg::*;

  localparam int HW = 2 * DW;

  logic signed [CW-1:0] crd [IN_FIELDS];

  logic                 v1, v2;
  logic signed [DW-1:0] a00_1, a10_1, a01_1, a11_1, b0_1, b1_1, sx_1, sy_1;
  logic signed [DW-1:0] a00_2, a10_2, a01_2, a11_2, sx_2, sy_2;
  logic signed [HW-1:0] md0_2, md1_2, ma0_2, ma1_2, mb0_2, mb1_2;

  // Take the low coordinate bits of each field as two's complement
  always_comb begin
    for (int k = 0; k < IN_FIELDS; k++) begin
      crd[k] = in_data[k*FIELD_W +: CW];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: edge vectors and endpoint sums
  always_ff @(posedge clk) begin
    if (en) begin
      a00_1 <= DW'(crd[0]) - DW'(crd[2]);
      a10_1 <= DW'(crd[1]) - DW'(crd[3]);
      a01_1 <= DW'(crd[6]) - DW'(crd[4]);
      a11_1 <= DW'(crd[7]) - DW'(crd[5]);
      b0_1  <= DW'(crd[6]) - DW'(crd[2]);
      b1_1  <= DW'(crd[7]) - DW'(crd[3]);
      sx_1  <= DW'(crd[2]) + DW'(crd[6]);
      sy_1  <= DW'(crd[3]) + DW'(crd[7]);
    end
  end

  // Stage 2: the six cross products
  always_ff @(posedge clk) begin
    if (en) begin
      md0_2 <= a00_1 * a11_1;
      md1_2 <= a01_1 * a10_1;
      ma0_2 <= b0_1 * a11_1;
      ma1_2 <= b1_1 * a01_1;
      mb0_2 <= b1_1 * a00_1;
      mb1_2 <= b0_1 * a10_1;
      a00_2 <= a00_1;
      a10_2 <= a10_1;
      a01_2 <= a01_1;
      a11_2 <= a11_1;
      sx_2  <= sx_1;
      sy_2  <= sy_1;
    end
  end

  // Stage 3: determinant and Cramer numerators
  always_ff @(posedge clk) begin
    if (en) begin
      det <= PW'(md0_2) - PW'(md1_2);
      na  <= PW'(ma0_2) - PW'(ma1_2);
      nb  <= PW'(mb0_2) - PW'(mb1_2);
      a00 <= a00_2;
      a10 <= a10_2;
      a01 <= a01_2;
      a11 <= a11_2;
      sx  <= sx_2;
      sy  <= sy_2;
    end
  end

endmodule
`default_nettype wire

### design/sgi_point.sv
// sgi_point: parallel and range tests, and the crossing point numerators.
// Three register stages with split multipliers; uses sgi_pkg.
`default_nettype none
module sgi_point #(
  parameter int CW = sgi_pkg::COORD_WIDTH,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW + 1,
  localparam int XW = 3 * DW + 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [PW-1:0]      det,
  input  wire logic signed [PW-1:0]      na,
  input  wire logic signed [PW-1:0]      nb,
  input  wire logic signed [DW-1:0]      a00,
  input  wire logic signed [DW-1:0]      a10,
  input  wire logic signed [DW-1:0]      a01,
  input  wire logic signed [DW-1:0]      a11,
  input  wire logic signed [DW-1:0]      sx,
  input  wire logic signed [DW-1:0]      sy,
  input  wire logic [sgi_pkg::THR_W-1:0] thr,
  output sgi_pkg::ctl_t                  out_ctl,
  output logic signed [XW-1:0]           nx,
  output logic signed [XW-1:0]           ny,
  output logic [PW-1:0]                  absdet,
  output logic                           det_neg
);
  import sgi_pkg::*;

  // Wide operand splits into a signed high part of DW bits and LW low bits
  localparam int LW = PW - DW;
  localparam int HW = 2 * DW;
  localparam int LPW = LW + 1 + DW;
  localparam int CMPW = (PW > THR_W) ? PW : THR_W;
  localparam int NPROD = 6;
  localparam logic signed [PW-1:0] ZERO = '0;

  logic signed [PW-1:0]  mc [NPROD];
  logic signed [DW-1:0]  mx [NPROD];
  logic signed [HW-1:0]  ph4 [NPROD];
  logic signed [LPW-1:0] pl4 [NPROD];
  logic signed [XW-1:0]  term5 [NPROD];

  logic          v4, v5;
  logic [PW-1:0] absdet4, absdet5;
  logic          dneg4, dneg5, zero4, cross4, cross5, par5;

  // 0 <= n/d <= 1 without dividing
  function automatic logic in_unit(input logic signed [PW-1:0] n,
                                   input logic signed [PW-1:0] d);
    logic ok;
    if (d[PW-1]) begin
      ok = (n <= ZERO) && (n >= d);
    end else begin
      ok = (n >= ZERO) && (n <= d);
    end
    return ok;
  endfunction

  // Operand pairs: det*s + na*a - nb*a for x, then y
  always_comb begin
    mc[0] = det; mx[0] = sx;
    mc[1] = na;  mx[1] = a00;
    mc[2] = nb;  mx[2] = a01;
    mc[3] = det; mx[3] = sy;
    mc[4] = na;  mx[4] = a10;
    mc[5] = nb;  mx[5] = a11;
  end

  // Stage 4 and 5 per product: partial products, then recombine
  for (genvar k = 0; k < NPROD; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        ph4[k]   <= $signed(mc[k][PW-1:LW]) * mx[k];
        pl4[k]   <= $signed({1'b0, mc[k][LW-1:0]}) * mx[k];
        term5[k] <= (XW'(ph4[k]) <<< LW) + XW'(pl4[k]);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4            <= 1'b0;
      v5            <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (en) begin
      v4            <= in_valid;
      v5            <= v4;
      out_ctl.valid <= v5;
    end
  end

  // Stage 4: magnitude and parameter range tests
  always_ff @(posedge clk) begin
    if (en) begin
      absdet4 <= det[PW-1] ? -det : det;
      dneg4   <= det[PW-1];
      zero4   <= det == ZERO;
      cross4  <= in_unit(na, det) && in_unit(nb, det);
    end
  end

  // Stage 5: threshold compare
  always_ff @(posedge clk) begin
    if (en) begin
      par5    <= zero4 || (CMPW'(absdet4) < CMPW'(thr));
      absdet5 <= absdet4;
      dneg5   <= dneg4;
      cross5  <= cross4;
    end
  end

  // Stage 6: sum the point numerators
  always_ff @(posedge clk) begin
    if (en) begin
      nx               <= term5[0] + term5[1] - term5[2];
      ny               <= term5[3] + term5[4] - term5[5];
      absdet           <= absdet5;
      det_neg          <= dneg5;
      out_ctl.parallel <= par5;
      out_ctl.crosses  <= cross5;
    end
  end

endmodule
`default_nettype wire

### design/sgi_div.sv
// sgi_div: rounding divider for both point coordinates, one quotient bit per stage,
// with saturation at the end. Uses sgi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sgi_div #(
  parameter int CW = sgi_pkg::COORD_WIDTH,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW + 1,
  localparam int XW = 3 * DW + 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire sgi_pkg::ctl_t        in_ctl,
  input  wire logic signed [XW-1:0] nx,
  input  wire logic signed [XW-1:0] ny,
  input  wire logic [PW-1:0]        absdet,
  input  wire logic                 det_neg,
  output logic                      out_valid,
  output sgi_pkg::res_t             out_res
);
  import sgi_pkg::*;

  localparam int NW = XW;
  localparam int DDW = PW + 1;
  localparam int LAST = CW + 1;
  localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] HALF_M1 = HALF - 1'b1;

  logic signed [XW-1:0] num [2];
  logic [NW-1:0]        rem [2][LAST+1];
  logic                 neg [2][LAST+1];
  logic                 ovf [2][1:LAST];
  logic [CW-1:0]        quo [2][1:LAST];
  logic [DDW-1:0]       d2 [LAST+1];
  ctl_t                 ctl [LAST+1];
  logic [FIELD_W-1:0]   lane_out [2];

  always_comb begin
    num[0] = nx;
    num[1] = ny;
  end

  // Shared control and divisor line
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= {absdet, 1'b0};
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s] <= '0;
      end else if (en) begin
        ctl[s] <= ctl[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2[s] <= d2[s-1];
      end
    end
  end

  for (genvar gl = 0; gl < 2; gl++) begin : g_lane
    logic [CW-1:0]        qv, mag;
    logic signed [CW-1:0] sres;

    // Rounding dividend |num| + |det| and result sign
    always_ff @(posedge clk) begin
      if (en) begin
        rem[gl][0] <= (num[gl][XW-1] ? NW'(-num[gl]) : NW'(num[gl])) + NW'(absdet);
        neg[gl][0] <= num[gl][XW-1] ^ det_neg;
      end
    end

    // Flag quotients that cannot fit the coordinate width
    always_ff @(posedge clk) begin
      if (en) begin
        rem[gl][1] <= rem[gl][0];
        neg[gl][1] <= neg[gl][0];
        ovf[gl][1] <= rem[gl][0] >= (NW'(d2[0]) << CW);
        quo[gl][1] <= '0;
      end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar s = 2; s <= LAST; s++) begin : g_bit
      localparam int SH = LAST - s;
      logic [NW:0] diff;

      always_comb begin
        diff = {1'b0, rem[gl][s-1]} - {1'b0, (NW'(d2[s-1]) << SH)};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[gl][s] <= diff[NW] ? rem[gl][s-1] : diff[NW-1:0];
          quo[gl][s] <= {quo[gl][s-1][CW-2:0], ~diff[NW]};
          neg[gl][s] <= neg[gl][s-1];
          ovf[gl][s] <= ovf[gl][s-1];
        end
      end
    end

    // Saturate to the signed coordinate range and widen to the field
    always_comb begin
      qv = quo[gl][LAST];
      if (neg[gl][LAST]) begin
        mag  = (ovf[gl][LAST] || qv > HALF) ? HALF : qv;
        sres = -mag;
      end else begin
        mag  = (ovf[gl][LAST] || qv > HALF_M1) ? HALF_M1 : qv;
        sres = mag;
      end
      lane_out[gl] = FIELD_W'(sres);
    end
  end

  // Zero the point and clear crosses of a parallel pair
  always_comb begin
    out_valid        = ctl[LAST].valid;
    out_res.parallel = ctl[LAST].parallel;
    out_res.crosses  = ctl[LAST].crosses && !ctl[LAST].parallel;
    out_res.cross_x  = ctl[LAST].parallel ? '0 : lane_out[0];
    out_res.cross_y  = ctl[LAST].parallel ? '0 : lane_out[1];
  end

  `SGI_ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(ctl[LAST]), "last stage moved during stall")
  `SGI_ASSERT(a_x_range, clk, rst, out_valid |-> (($signed(out_res.cross_x) >>> (CW-1)) == 0 || ($signed(out_res.cross_x) >>> (CW-1)) == -1), "cross_x outside coordinate range")
  `SGI_ASSERT(a_y_range, clk, rst, out_valid |-> (($signed(out_res.cross_y) >>> (CW-1)) == 0 || ($signed(out_res.cross_y) >>> (CW-1)) == -1), "cross_y outside coordinate range")

endmodule
`default_nettype wire

### design/sgi_outq.sv
// sgi_outq: two-entry result queue between the pipeline and the output stream.
// Uses sgi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sgi_outq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire sgi_pkg::res_t                  push_res,
  output logic                                ready,
  output logic                                tvalid,
  input  wire logic                           tready,
  // cross_x, cross_y
  output logic [sgi_pkg::OUT_DATA_W-1:0]      tdata,
  // crosses, parallel
  output logic [sgi_pkg::OUT_USER_W-1:0]      tuser
);
  import sgi_pkg::*;

  res_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       pop;

  assign ready  = count != 2'd2;
  assign tvalid = count != 2'd0;
  assign pop    = tvalid && tready;
  assign tdata  = {slot[rptr].cross_y, slot[rptr].cross_x};
  assign tuser  = {slot[rptr].parallel, slot[rptr].crosses};

  // Store incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_res;
    end
  end

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `SGI_ASSERT(a_no_overfill, clk, rst, push |-> count != 2'd2, "push into a full queue")
  `SGI_ASSERT_NEXT(a_fill_up, clk, rst, push && !pop, count == $past(count) + 2'd1, "fill level missed a push")
  `SGI_ASSERT_NEXT(a_fill_down, clk, rst, pop && !push, count == $past(count) - 2'd1, "fill level missed a transfer out")

endmodule
`default_nettype wire

### design/segment_intersection_2d.sv
// Crossing of two 2-D line segments, fully pipelined.
// Each transfer on s_axis carries P1, P2, Q1, Q2 as signed fixed-point
// coordinates; each transfer on m_axis carries one result: the midpoint of
// the two parametric points, rounded to nearest (ties away from zero) and
// saturated, plus crosses and parallel flags in tuser. A parallel pair
// reports a zero point and crosses low.
// cfg_valid/cfg_data write parallel_threshold (63 bits, reset 1); write it
// only while no item is in flight. cfg_ready is always high.
// Throughput: one item per cycle while the result queue has room. The path
// from the accepting edge to m_axis_tvalid runs through three product
// stages, three test and point stages, two divider setup stages, one
// restoring divider stage per quotient bit and the result queue register.
// Reset clears all valid bits and the result queue and sets the threshold
// to 1. A two-entry queue holds results; when it is full the whole pipeline
// holds and s_axis_tready drops, so a stalled receiver loses nothing.
// Uses sgi_pkg, sgi_front, sgi_point, sgi_div, sgi_outq.
`default_nettype none
module segment_intersection_2d #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y
  input  wire logic [sgi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // cross_x, cross_y
  output logic [sgi_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // crosses, parallel
  output logic [sgi_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sgi_pkg::THR_W-1:0]      cfg_data
);
  import sgi_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW + 1;
  localparam int XW = 3 * DW + 3;

  logic             en;
  logic [THR_W-1:0] thr;

  logic                 f_valid;
  logic signed [PW-1:0] f_det, f_na, f_nb;
  logic signed [DW-1:0] f_a00, f_a10, f_a01, f_a11, f_sx, f_sy;

  ctl_t                 p_ctl;
  logic signed [XW-1:0] p_nx, p_ny;
  logic [PW-1:0]        p_absdet;
  logic                 p_det_neg;

  logic d_valid;
  res_t d_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = en;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  sgi_front #(.CW(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .det       (f_det),
    .na        (f_na),
    .nb        (f_nb),
    .a00       (f_a00),
    .a10       (f_a10),
    .a01       (f_a01),
    .a11       (f_a11),
    .sx        (f_sx),
    .sy        (f_sy)
  );

  sgi_point #(.CW(COORD_WIDTH)) u_point (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .det      (f_det),
    .na       (f_na),
    .nb       (f_nb),
    .a00      (f_a00),
    .a10      (f_a10),
    .a01      (f_a01),
    .a11      (f_a11),
    .sx       (f_sx),
    .sy       (f_sy),
    .thr      (thr),
    .out_ctl  (p_ctl),
    .nx       (p_nx),
    .ny       (p_ny),
    .absdet   (p_absdet),
    .det_neg  (p_det_neg)
  );

  sgi_div #(.CW(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (p_ctl),
    .nx        (p_nx),
    .ny        (p_ny),
    .absdet    (p_absdet),
    .det_neg   (p_det_neg),
    .out_valid (d_valid),
    .out_res   (d_res)
  );

  sgi_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (d_valid && en),
    .push_res (d_res),
    .ready    (en),
    .tvalid   (m_axis_tvalid),
    .tready   (m_axis_tready),
    .tdata    (m_axis_tdata),
    .tuser    (m_axis_tuser)
  );

endmodule
`default_nettype wire

### sim/segment_intersection_2d_checker.sv
// Checker for segment_intersection_2d: watches the config, input and output
// channels, predicts each result and compares it in order. Uses sgi_pkg.
`default_nettype none
module segment_intersection_2d_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [sgi_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [sgi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [sgi_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [sgi_pkg::THR_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import sgi_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic [THR_W-1:0] threshold;
  res_t             crossing_q[$];

  function automatic wide_t mag(wide_t v);
    return v[127] ? -v : v;
  endfunction

  // Round num/(2*det) to nearest, ties away from zero, then saturate
  function automatic logic [31:0] round_point(wide_t num, wide_t det);
    logic [127:0] an;
    logic [127:0] ad;
    logic [127:0] q;
    an = mag(num);
    ad = mag(det);
    q = (an + ad) / (ad + ad);
    if (num[127] != det[127]) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // True when 0 <= n/det <= 1
  function automatic logic in_unit(wide_t n, wide_t det);
    if (det[127]) begin
      n = -n;
      det = -det;
    end
    return !n[127] && (n <= det);
  endfunction

  function automatic res_t predict_crossing(logic [IN_DATA_W-1:0] d, logic [THR_W-1:0] thr);
    wide_t c[8];
    wide_t a00, a10, a01, a11, b0, b1, det, na, nb, nx, ny;
    res_t  r;
    for (int i = 0; i < 8; i++) c[i] = $signed(d[32*i +: 32]);
    a00 = c[0] - c[2];
    a10 = c[1] - c[3];
    a01 = c[6] - c[4];
    a11 = c[7] - c[5];
    b0 = c[6] - c[2];
    b1 = c[7] - c[3];
    det = a00 * a11 - a01 * a10;
    r = '0;
    if (det == 0 || mag(det) < wide_t'({65'b0, thr})) begin
      r.parallel = 1'b1;
      return r;
    end
    na = b0 * a11 - b1 * a01;
    nb = b1 * a00 - b0 * a10;
    nx = det * (c[2] + c[6]) + na * a00 - nb * a01;
    ny = det * (c[3] + c[7]) + na * a10 - nb * a11;
    r.crosses = in_unit(na, det) && in_unit(nb, det);
    r.cross_x = round_point(nx, det);
    r.cross_y = round_point(ny, det);
    return r;
  endfunction

  // Track the threshold, queue predictions, compare transfers out
  always_ff @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      threshold <= THR_RESET;
      crossing_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        crossing_q.insert(crossing_q.size(), predict_crossing(s_axis_tdata, threshold));
      if (m_axis_tvalid && m_axis_tready) begin
        got.crosses = m_axis_tuser[0];
        got.parallel = m_axis_tuser[1];
        got.cross_x = m_axis_tdata[31:0];
        got.cross_y = m_axis_tdata[63:32];
        if (crossing_q.size() == 0) begin
          $display("%0t: result with none expected: par=%b cr=%b x=%h y=%h", $time,
                   got.parallel, got.crosses, got.cross_x, got.cross_y);
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected par=%b cr=%b x=%h y=%h, got par=%b cr=%b x=%h y=%h",
                     $time, want.parallel, want.crosses, want.cross_x, want.cross_y,
                     got.parallel, got.crosses, got.cross_x, got.cross_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= crossing_q.size();
  end
endmodule
`default_nettype wire

### sim/tb_segment_intersection_2d.sv
// Testbench top for segment_intersection_2d: drives segment pairs and
// threshold writes, stalls both sides. Uses sgi_pkg and the checker module.
`default_nettype none
module tb_segment_intersection_2d;
  import sgi_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [THR_W-1:0]      cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    pairs_sent = 0;
  logic                  no_gaps = 1'b0;
  int                    cycles = 0;

  segment_intersection_2d dut (.*);

  segment_intersection_2d_checker chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_pair(
      logic [31:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y);
    return {q2y, q2x, q1y, q1x, p2y, p2x, p1y, p1x};
  endfunction

  // Coordinate within +-2^span_bits whole units, random fraction
  function automatic logic [31:0] near_coord(int unsigned span_bits);
    logic [31:0] v;
    v = $urandom;
    return 32'($signed(v) >>> (15 - span_bits));
  endfunction

  task automatic send_pair(logic [IN_DATA_W-1:0] d);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    pairs_sent++;
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pairs(int count);
    logic [31:0] c[8];
    int unsigned span;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: for (int i = 0; i < 8; i++) c[i] = $urandom;
        2: begin
          // Nearly parallel: second segment is the first shifted slightly
          span = $urandom_range(0, 15);
          for (int i = 0; i < 4; i++) c[i] = near_coord(span);
          for (int i = 0; i < 4; i++) c[i + 4] = c[i] + $urandom_range(0, 3) - 1;
          c[4] = c[4] + $urandom_range(0, 8'hFF);
        end
        3: begin
          // Shared endpoint
          span = $urandom_range(0, 15);
          for (int i = 0; i < 8; i++) c[i] = near_coord(span);
          c[4] = c[0];
          c[5] = c[1];
        end
        default: begin
          span = $urandom_range(0, 15);
          for (int i = 0; i < 8; i++) c[i] = near_coord(span);
        end
      endcase
      send_pair(pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]));
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off partway through
  initial begin
    bit held;
    int gap;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && pairs_sent > 300) begin
        held = 1;
        m_axis_tready <= 1'b0;
        for (int k = 0; k < 400; k++) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases at reset threshold
    send_pair('0);                                                 // all zero: parallel
    send_pair(pack_pair(0, 0, ONE, ONE, 0, ONE, ONE, 0));          // unit X crossing
    send_pair(pack_pair(0, 0, ONE, 0, ONE, 0, ONE, ONE));          // touch at endpoint
    send_pair(pack_pair(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE));   // lines cross off P
    send_pair(pack_pair(0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE));      // exact parallel
    send_pair(pack_pair(0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0));        // collinear overlap
    send_pair(pack_pair(0, 0, 1, 0, 0, 0, 0, 1));                  // det of one unit
    send_pair(pack_pair(0, 0, 1, 1, 0, 1, 1, 0));                  // half-step rounding
    send_pair(pack_pair(0, 0, -1, -1, 0, -1, -1, 0));              // negative tie
    send_pair({8{32'h7FFF_FFFF}});                                 // all max: parallel
    send_pair({8{32'h8000_0000}});                                 // all min: parallel
    send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_pair(pack_pair(0, 0, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));            // far saturation +
    send_pair(pack_pair(0, 0, -1, 0, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF));            // far saturation -
    send_pair(pack_pair(0, 0, 1, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF, 2));
    send_pair(pack_pair(ONE, ONE, 0, 0, ONE, 0, 0, ONE));          // reversed direction
    random_pairs(200);

    // Zero threshold: only exact zero determinant is parallel
    write_threshold('0);
    send_pair(pack_pair(0, 0, 1, 0, 0, 0, 0, 1));
    send_pair(pack_pair(0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE));
    random_pairs(200);

    // Largest threshold: mostly parallel
    write_threshold({THR_W{1'b1}});
    send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    random_pairs(120);

    // Mid threshold around one square unit
    write_threshold(THR_W'(64'h1_0000_0000));
    send_pair(pack_pair(0, 0, ONE, 0, 0, 0, 0, ONE));
    send_pair(pack_pair(0, 0, ONE, 0, 0, 0, 0, ONE - 1));
    random_pairs(200);

    write_threshold(THR_W'({$urandom, $urandom}));
    random_pairs(120);

    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/sgi_pkg.sv
design/sgi_front.sv
design/sgi_point.sv
design/sgi_div.sv
design/sgi_outq.sv
design/segment_intersection_2d.sv
sim/segment_intersection_2d_checker.sv
sim/tb_segment_intersection_2d.sv
